// ===== src/mrfb_pkg.sv =====
// Package for the multi-ring frame buffer: request kind codes, fixed field
// widths and the command/status structs between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mrfb_pkg;

  // fixed field widths
  localparam int KIND_W   = 3;
  localparam int SLOT_W   = 3;
  localparam int PROD_W   = 32;
  localparam int NAME_W   = 64;
  localparam int FOFF_W   = 5;
  localparam int POS_W    = 6;
  localparam int SAMPLE_W = 32;
  localparam int AVAIL_W  = 5;
  localparam int BLOCK_W  = 7;

  localparam logic [BLOCK_W-1:0] BLOCK_RESET = 7'd64;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;
    logic do_match;
    logic table_load;
    logic walk_init;
    logic do_find;
    logic load_frame;
    logic reduce_frame;
    logic calc_addr;
    logic mem_access;
    logic walk_step;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              found;
    logic              frame_big;
    logic              walk_last;
    logic              out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/mrfb_ctrl.sv =====
// Controller state machine of the multi-ring frame buffer.
// Depends on mrfb_pkg; drives the datapath only through cmd_t / sts_t.
`timescale 1ns / 1ps
`default_nettype none

module mrfb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mrfb_pkg::sts_t sts,
  output mrfb_pkg::cmd_t     cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MATCH  = 8'b0000_0010,
    S_FIND   = 8'b0000_0100,
    S_SELECT = 8'b0000_1000,
    S_FRAME  = 8'b0001_0000,
    S_MEM    = 8'b0010_0000,
    S_WALK   = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic is_rw;

  assign in_ready = (state_r == S_IDLE);
  assign is_rw    = (sts.kind == mrfb_pkg::KIND_WRITE) || (sts.kind == mrfb_pkg::KIND_READ);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.do_match = 1'b1;
        unique case (sts.kind) inside
          mrfb_pkg::KIND_LOAD: begin
            cmd.table_load = 1'b1;
            state_nxt      = S_RESULT;
          end
          mrfb_pkg::KIND_ADVANCE: begin
            cmd.walk_init = 1'b1;
            state_nxt     = S_WALK;
          end
          mrfb_pkg::KIND_WRITE, mrfb_pkg::KIND_READ, mrfb_pkg::KIND_QUERY: begin
            state_nxt = S_FIND;
          end
          default: state_nxt = S_RESULT;
        endcase
      end
      S_FIND: begin
        cmd.do_find = 1'b1;
        state_nxt   = S_SELECT;
      end
      S_SELECT: begin
        if (sts.found && is_rw) begin
          cmd.load_frame = 1'b1;
          state_nxt      = S_FRAME;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_FRAME: begin
        // wrap the frame index before forming the address
        if (sts.frame_big) begin
          cmd.reduce_frame = 1'b1;
        end else begin
          cmd.calc_addr = 1'b1;
          state_nxt     = S_MEM;
        end
      end
      S_MEM: begin
        cmd.mem_access = 1'b1;
        state_nxt      = S_RESULT;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_MATCH)
    else $error("accepted request did not start a lookup");
  a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over an untaken result");
  a_mem_needs_ring: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MEM |-> sts.found && is_rw)
    else $error("sample store access without a matching ring");
  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK && sts.walk_last |=> state_r == S_RESULT)
    else $error("advance walk did not finish at the last ring");
`endif

endmodule

`default_nettype wire

// ===== src/mrfb_dp.sv =====
// Datapath of the multi-ring frame buffer: ring table, frame pointers,
// sample store, block size register and result register. Depends on mrfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrfb_dp #(
  parameter int NUM_RINGS       = 8,
  parameter int FRAMES_PER_RING = 30,
  parameter int MAX_BLOCK       = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [mrfb_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [mrfb_pkg::SLOT_W-1:0]   in_ring_slot,
  input  wire logic [mrfb_pkg::PROD_W-1:0]   in_producer_id,
  input  wire logic [mrfb_pkg::NAME_W-1:0]   in_name_hash,
  input  wire logic [mrfb_pkg::FOFF_W-1:0]   in_frame_offset,
  input  wire logic [mrfb_pkg::POS_W-1:0]    in_sample_pos,
  input  wire logic [mrfb_pkg::SAMPLE_W-1:0] in_sample_in,
  input  wire logic                          in_frame_end,
  input  wire logic                          cfg_we,
  input  wire logic [mrfb_pkg::BLOCK_W-1:0]  cfg_block_size,
  input  wire mrfb_pkg::cmd_t                cmd,
  output mrfb_pkg::sts_t                     sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mrfb_pkg::SAMPLE_W-1:0]      out_sample_out,
  output logic [mrfb_pkg::AVAIL_W-1:0]       out_available_count,
  output logic                               out_has_room,
  output logic                               out_not_found
);

  localparam int RW       = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
  localparam int FW       = $clog2(FRAMES_PER_RING + 1);
  localparam int TW       = FW + 1;
  localparam int SW       = $clog2(FRAMES_PER_RING + 32);
  localparam int DEPTH    = NUM_RINGS * FRAMES_PER_RING * MAX_BLOCK;
  localparam int AW       = $clog2(DEPTH);
  localparam int ROW_SPAN = FRAMES_PER_RING * MAX_BLOCK;
  localparam int MBW      = $clog2(MAX_BLOCK + 1);
  localparam int EW       = (MBW > mrfb_pkg::BLOCK_W) ? MBW : mrfb_pkg::BLOCK_W;

  // latched request
  logic [mrfb_pkg::KIND_W-1:0]   kind_r;
  logic [mrfb_pkg::SLOT_W-1:0]   slot_in_r;
  logic [mrfb_pkg::PROD_W-1:0]   prod_r;
  logic [mrfb_pkg::NAME_W-1:0]   name_r;
  logic [mrfb_pkg::FOFF_W-1:0]   foff_r;
  logic [mrfb_pkg::POS_W-1:0]    pos_r;
  logic [mrfb_pkg::SAMPLE_W-1:0] sample_r;
  logic                          fend_r;

  logic [mrfb_pkg::BLOCK_W-1:0]  block_size_r;

  // ring table and pointers
  logic [mrfb_pkg::PROD_W-1:0] prod_tab_r [NUM_RINGS];
  logic [mrfb_pkg::NAME_W-1:0] name_tab_r [NUM_RINGS];
  logic [FW-1:0]               head_r     [NUM_RINGS];
  logic [FW-1:0]               tail_r     [NUM_RINGS];
  logic [FW-1:0]               ready_r    [NUM_RINGS];

  logic [NUM_RINGS-1:0] match_r, match_nxt;
  logic [RW-1:0]        slot_r, find_slot;
  logic                 found_r, find_hit;
  logic [SW-1:0]        frame_r;
  logic [AW-1:0]        addr_r;
  logic                 pos_ok_r;

  logic [mrfb_pkg::SAMPLE_W-1:0] store_mem [DEPTH];
  logic [mrfb_pkg::SAMPLE_W-1:0] rdata_r;
  logic                          mem_we, mem_re;

  logic [FW-1:0] head_sel, tail_sel, ready_sel, head_inc;
  logic [TW-1:0] walk_sum;
  logic [31:0]   ready_ext;
  logic [EW-1:0] eff_block;
  logic          use_prod;

  logic                          out_valid_r;
  logic [mrfb_pkg::SAMPLE_W-1:0] out_sample_r;
  logic [mrfb_pkg::AVAIL_W-1:0]  out_avail_r;
  logic                          out_room_r;
  logic                          out_nf_r;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r    <= in_kind;
      slot_in_r <= in_ring_slot;
      prod_r    <= in_producer_id;
      name_r    <= in_name_hash;
      foff_r    <= in_frame_offset;
      pos_r     <= in_sample_pos;
      sample_r  <= in_sample_in;
      fend_r    <= in_frame_end;
    end
  end

  // block size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= mrfb_pkg::BLOCK_RESET;
    end else if (cfg_we) begin
      block_size_r <= cfg_block_size;
    end
  end

  // effective block size: zero means one, clipped at MAX_BLOCK
  always_comb begin
    if (block_size_r == '0) begin
      eff_block = EW'(1);
    end else if (EW'(block_size_r) > EW'(MAX_BLOCK)) begin
      eff_block = EW'(MAX_BLOCK);
    end else begin
      eff_block = EW'(block_size_r);
    end
  end

  // per-entry name (and producer) compare
  assign use_prod = (kind_r == mrfb_pkg::KIND_WRITE);

  always_comb begin
    for (int i = 0; i < NUM_RINGS; i++) begin
      match_nxt[i] = (name_tab_r[i] == name_r) && (!use_prod || (prod_tab_r[i] == prod_r));
    end
  end

  // lowest matching entry wins
  always_comb begin
    find_slot = '0;
    find_hit  = 1'b0;
    for (int i = NUM_RINGS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        find_slot = RW'(i);
        find_hit  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_match) match_r <= match_nxt;
    if (cmd.do_find) begin
      slot_r  <= find_slot;
      found_r <= find_hit;
    end else if (cmd.walk_init) begin
      slot_r <= '0;
    end else if (cmd.walk_step) begin
      slot_r <= slot_r + RW'(1);
    end
  end

  // ring table load; slots past the table are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_RINGS; i++) begin
        prod_tab_r[i] <= '0;
        name_tab_r[i] <= '0;
      end
    end else if (cmd.table_load) begin
      for (int i = 0; i < NUM_RINGS; i++) begin
        if (7'(slot_in_r) == 7'(i)) begin
          prod_tab_r[i] <= prod_r;
          name_tab_r[i] <= name_r;
        end
      end
    end
  end

  // selected ring pointers
  assign head_sel  = head_r[slot_r];
  assign tail_sel  = tail_r[slot_r];
  assign ready_sel = ready_r[slot_r];
  assign head_inc  = (head_sel == FW'(FRAMES_PER_RING - 1)) ? '0 : head_sel + FW'(1);
  assign walk_sum  = TW'(tail_sel) + TW'(ready_sel);
  assign ready_ext = 32'(ready_sel);

  // frame index: head for writes, tail plus offset for reads, then wrap
  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      if (kind_r == mrfb_pkg::KIND_WRITE) begin
        frame_r <= SW'(head_sel);
      end else begin
        frame_r <= SW'(tail_sel) + SW'(foff_r);
      end
    end else if (cmd.reduce_frame) begin
      frame_r <= frame_r - SW'(FRAMES_PER_RING);
    end
  end

  // store address and position check
  always_ff @(posedge clk) begin
    if (cmd.calc_addr) begin
      addr_r   <= AW'(slot_r) * AW'(ROW_SPAN) + AW'(frame_r) * AW'(MAX_BLOCK) + AW'(pos_r);
      pos_ok_r <= (EW'(pos_r) < eff_block);
    end
  end

  // frame pointer updates: frame completion and advance walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_RINGS; i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        ready_r[i] <= '0;
      end
    end else if (cmd.mem_access && (kind_r == mrfb_pkg::KIND_WRITE) && fend_r) begin
      head_r[slot_r] <= head_inc;
      if (ready_sel < FW'(FRAMES_PER_RING)) ready_r[slot_r] <= ready_sel + FW'(1);
    end else if (cmd.walk_step) begin
      if (walk_sum >= TW'(FRAMES_PER_RING)) begin
        tail_r[slot_r] <= FW'(walk_sum - TW'(FRAMES_PER_RING));
      end else begin
        tail_r[slot_r] <= FW'(walk_sum);
      end
      ready_r[slot_r] <= '0;
    end
  end

  // sample store, one port, registered read
  assign mem_we = cmd.mem_access && (kind_r == mrfb_pkg::KIND_WRITE) && pos_ok_r;
  assign mem_re = cmd.mem_access && (kind_r == mrfb_pkg::KIND_READ) && pos_ok_r;

  always_ff @(posedge clk) begin
    if (mem_we) store_mem[addr_r] <= sample_r;
    if (mem_re) rdata_r <= store_mem[addr_r];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sample_r <= '0;
      out_avail_r  <= '0;
      out_room_r   <= 1'b0;
      out_nf_r     <= 1'b0;
      case (kind_r) inside
        mrfb_pkg::KIND_WRITE, mrfb_pkg::KIND_READ, mrfb_pkg::KIND_QUERY: begin
          if (!found_r) begin
            out_nf_r <= 1'b1;
          end else begin
            out_avail_r <= ready_ext[mrfb_pkg::AVAIL_W-1:0];
            if (kind_r == mrfb_pkg::KIND_WRITE) begin
              out_room_r <= fend_r && (ready_sel < FW'(FRAMES_PER_RING));
            end
            if ((kind_r == mrfb_pkg::KIND_READ) && pos_ok_r) begin
              out_sample_r <= rdata_r;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sample_out      = out_sample_r;
  assign out_available_count = out_avail_r;
  assign out_has_room        = out_room_r;
  assign out_not_found       = out_nf_r;

  // status to controller
  assign sts.kind      = kind_r;
  assign sts.found     = found_r;
  assign sts.frame_big = (frame_r >= SW'(FRAMES_PER_RING));
  assign sts.walk_last = (slot_r == RW'(NUM_RINGS - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// ===== src/multi_ring_frame_buffer_unit.sv =====
// Top level of the multi-ring frame buffer: controller plus datapath.
// Depends on mrfb_pkg, mrfb_ctrl and mrfb_dp.
//
// Several named rings of audio frames share one single-port sample store.
// One request is worked at a time; a new one is taken while the previous
// result still waits on the output register. Load and unknown kinds go
// from the match step to the result; query adds the find and select
// steps; write and read add the frame, address and store steps, the frame
// step repeating for each subtraction of FRAMES_PER_RING needed to wrap the
// tail-plus-offset frame index (none or one when FRAMES_PER_RING is 32 or
// more); advance walks the rings one per cycle. The steps are set by the
// registered name compare and priority pick over the ring table and the
// single sample store port. Both block_size and the store need no clearing
// pass; samples never written read as undefined. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module multi_ring_frame_buffer_unit #(
  parameter int NUM_RINGS       = 8,
  parameter int FRAMES_PER_RING = 30,
  parameter int MAX_BLOCK       = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mrfb_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [mrfb_pkg::SLOT_W-1:0]   in_ring_slot,
  input  wire logic [mrfb_pkg::PROD_W-1:0]   in_producer_id,
  input  wire logic [mrfb_pkg::NAME_W-1:0]   in_name_hash,
  input  wire logic [mrfb_pkg::FOFF_W-1:0]   in_frame_offset,
  input  wire logic [mrfb_pkg::POS_W-1:0]    in_sample_pos,
  input  wire logic [mrfb_pkg::SAMPLE_W-1:0] in_sample_in,
  input  wire logic                          in_frame_end,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mrfb_pkg::SAMPLE_W-1:0]      out_sample_out,
  output logic [mrfb_pkg::AVAIL_W-1:0]       out_available_count,
  output logic                               out_has_room,
  output logic                               out_not_found,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mrfb_pkg::BLOCK_W-1:0]  cfg_block_size
);

  mrfb_pkg::cmd_t cmd;
  mrfb_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  mrfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrfb_dp #(
    .NUM_RINGS       (NUM_RINGS),
    .FRAMES_PER_RING (FRAMES_PER_RING),
    .MAX_BLOCK       (MAX_BLOCK)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_kind             (in_kind),
    .in_ring_slot        (in_ring_slot),
    .in_producer_id      (in_producer_id),
    .in_name_hash        (in_name_hash),
    .in_frame_offset     (in_frame_offset),
    .in_sample_pos       (in_sample_pos),
    .in_sample_in        (in_sample_in),
    .in_frame_end        (in_frame_end),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_block_size      (cfg_block_size),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_sample_out      (out_sample_out),
    .out_available_count (out_available_count),
    .out_has_room        (out_has_room),
    .out_not_found       (out_not_found)
  );

endmodule

`default_nettype wire

// ===== tb/tb_multi_ring_frame_buffer_unit.sv =====
// Self-checking testbench for multi_ring_frame_buffer_unit: directed and random
// ring requests, block size changes and output stalls, checked against a local model.
// Depends on mrfb_pkg and the multi_ring_frame_buffer_unit RTL.
`timescale 1ns / 1ps

module tb_multi_ring_frame_buffer_unit;

  localparam int RINGS       = 8;
  localparam int FRAMES      = 30;
  localparam int MAXBLK      = 64;
  localparam int STORE_DEPTH = RINGS * FRAMES * MAXBLK;
  localparam int SETTLE      = 20;    // covers the longest request (advance walk)
  localparam int TAIL_CYCLES = 30;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef logic [mrfb_pkg::KIND_W-1:0]   kind_t;
  typedef logic [mrfb_pkg::SLOT_W-1:0]   slot_t;
  typedef logic [mrfb_pkg::PROD_W-1:0]   prod_t;
  typedef logic [mrfb_pkg::NAME_W-1:0]   name_t;
  typedef logic [mrfb_pkg::FOFF_W-1:0]   foff_t;
  typedef logic [mrfb_pkg::POS_W-1:0]    pos_t;
  typedef logic [mrfb_pkg::SAMPLE_W-1:0] word_t;
  typedef logic [mrfb_pkg::AVAIL_W-1:0]  avail_t;
  typedef logic [mrfb_pkg::BLOCK_W-1:0]  block_t;

  localparam prod_t PROD_A = 32'hFFFF_FFFF;
  localparam name_t TAG_A  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam name_t TAG_N  = 64'h8000_0000_0000_0001;

  typedef enum {MIX_NORMAL, MIX_FILL} mix_t;

  typedef struct packed {
    kind_t kind;
    slot_t slot;
    prod_t producer;
    name_t name;
    foff_t foff;
    pos_t  pos;
    word_t sample;
    logic  frame_end;
  } req_t;

  typedef struct packed {
    word_t  word;
    avail_t avail;
    logic   room;
    logic   missing;
  } result_t;

  // DUT signals
  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  kind_t  in_kind;
  slot_t  in_ring_slot;
  prod_t  in_producer_id;
  name_t  in_name_hash;
  foff_t  in_frame_offset;
  pos_t   in_sample_pos;
  word_t  in_sample_in;
  logic   in_frame_end;
  logic   out_valid;
  logic   out_ready;
  word_t  out_sample_out;
  avail_t out_available_count;
  logic   out_has_room;
  logic   out_not_found;
  logic   cfg_valid;
  logic   cfg_ready;
  block_t cfg_block_size;

  // ring model state
  prod_t       ring_owner[RINGS];
  name_t       ring_tag[RINGS];
  int unsigned head_idx[RINGS];
  int unsigned tail_idx[RINGS];
  int unsigned ready_frames[RINGS];
  word_t       sample_mem[STORE_DEPTH];
  bit          sample_written[STORE_DEPTH];
  int unsigned recent_frame[RINGS];
  int unsigned recent_pos[RINGS];
  bit          recent_ok[RINGS];
  block_t      block_reg;

  // results still owed by the block, oldest first
  result_t     due_results[$];
  int          fault_count;

  // stimulus helpers
  prod_t       id_pool[4];
  name_t       tag_pool[4];
  bit          feed_calm;
  int          hold_req;

  multi_ring_frame_buffer_unit #(
    .NUM_RINGS      (RINGS),
    .FRAMES_PER_RING(FRAMES),
    .MAX_BLOCK      (MAXBLK)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_ring_slot       (in_ring_slot),
    .in_producer_id     (in_producer_id),
    .in_name_hash       (in_name_hash),
    .in_frame_offset    (in_frame_offset),
    .in_sample_pos      (in_sample_pos),
    .in_sample_in       (in_sample_in),
    .in_frame_end       (in_frame_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sample_out     (out_sample_out),
    .out_available_count(out_available_count),
    .out_has_room       (out_has_room),
    .out_not_found      (out_not_found),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_block_size     (cfg_block_size)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  // block size as the datapath applies it
  function automatic int unsigned block_len();
    if (block_reg == 0) return 1;
    if (block_reg > MAXBLK) return MAXBLK;
    return 32'(block_reg);
  endfunction

  function automatic int unsigned mem_addr(int unsigned r, int unsigned f, int unsigned p);
    return (r * FRAMES + f) * MAXBLK + p;
  endfunction

  // lowest matching table entry, RINGS when none
  function automatic int find_ring(bit by_owner, prod_t owner, name_t tag);
    for (int i = 0; i < RINGS; i++)
      if (ring_tag[i] == tag && (!by_owner || ring_owner[i] == owner)) return i;
    return RINGS;
  endfunction

  // apply one request to the ring model and return the result it yields
  function automatic result_t predict_ring_result(req_t q);
    result_t     res;
    int          hit;
    int unsigned h;
    int unsigned f;
    int unsigned len;
    res = '0;
    len = block_len();
    case (q.kind)
      mrfb_pkg::KIND_LOAD: begin
        if (q.slot < RINGS) begin
          ring_owner[q.slot] = q.producer;
          ring_tag[q.slot]   = q.name;
        end
      end
      mrfb_pkg::KIND_WRITE: begin
        hit = find_ring(1'b1, q.producer, q.name);
        if (hit == RINGS) res.missing = 1'b1;
        else begin
          h = head_idx[hit] % FRAMES;
          if (q.pos < len) begin
            sample_mem[mem_addr(hit, h, 32'(q.pos))]     = q.sample;
            sample_written[mem_addr(hit, h, 32'(q.pos))] = 1'b1;
            recent_frame[hit] = h;
            recent_pos[hit]   = 32'(q.pos);
            recent_ok[hit]    = 1'b1;
          end
          if (q.frame_end) begin
            head_idx[hit] = (h + 1) % FRAMES;
            if (ready_frames[hit] < FRAMES) ready_frames[hit]++;
            res.room = (ready_frames[hit] < FRAMES);
          end
          res.avail = avail_t'(ready_frames[hit]);
        end
      end
      mrfb_pkg::KIND_READ: begin
        hit = find_ring(1'b0, '0, q.name);
        if (hit == RINGS) res.missing = 1'b1;
        else begin
          f = (tail_idx[hit] + 32'(q.foff)) % FRAMES;
          if (q.pos < len) res.word = sample_mem[mem_addr(hit, f, 32'(q.pos))];
          res.avail = avail_t'(ready_frames[hit]);
        end
      end
      mrfb_pkg::KIND_QUERY: begin
        hit = find_ring(1'b0, '0, q.name);
        if (hit == RINGS) res.missing = 1'b1;
        else res.avail = avail_t'(ready_frames[hit]);
      end
      mrfb_pkg::KIND_ADVANCE: begin
        for (int i = 0; i < RINGS; i++) begin
          tail_idx[i]     = (tail_idx[i] + ready_frames[i]) % FRAMES;
          ready_frames[i] = 0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ------------------------------------------------------------- drivers

  function automatic req_t pack_req(kind_t kind, slot_t slot, prod_t producer, name_t name,
                                    foff_t foff, pos_t pos, word_t sample, logic frame_end);
    req_t q;
    q.kind      = kind;
    q.slot      = slot;
    q.producer  = producer;
    q.name      = name;
    q.foff      = foff;
    q.pos       = pos;
    q.sample    = sample;
    q.frame_end = frame_end;
    return q;
  endfunction

  // offer one request; valid is left high on return so a back-to-back request
  // needs no extra edge
  task automatic send_req(input req_t q);
    int gap;
    gap = 0;
    while (!feed_calm && $urandom_range(99) < 12) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= q.kind;
    in_ring_slot    <= q.slot;
    in_producer_id  <= q.producer;
    in_name_hash    <= q.name;
    in_frame_offset <= q.foff;
    in_sample_pos   <= q.pos;
    in_sample_in    <= q.sample;
    in_frame_end    <= q.frame_end;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due_results.push_back(predict_ring_result(q));
  endtask

  // stop offering, wait for every owed result and let the block go quiet
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_block_size(input block_t value);
    settle_idle();
    cfg_valid      <= 1'b1;
    cfg_block_size <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    block_reg = value;
    cfg_valid <= 1'b0;
  endtask

  // build one random request; reads are steered away from unwritten samples
  task automatic make_req(input mix_t mix, output req_t q);
    int          roll;
    int          pick;
    int          hit;
    int unsigned len;
    int unsigned frame;
    bit          ok;
    len  = block_len();
    roll = $urandom_range(99);
    pick = (mix == MIX_FILL) ? $urandom_range(1) : $urandom_range(RINGS - 1);
    q = pack_req(mrfb_pkg::KIND_WRITE, slot_t'($urandom_range(RINGS - 1)), $urandom,
                 {$urandom, $urandom}, foff_t'($urandom_range(FRAMES - 1)),
                 pos_t'($urandom_range(MAXBLK - 1)), $urandom, 1'($urandom_range(1)));

    if (mix == MIX_FILL) begin
      if (roll < 70) q.kind = mrfb_pkg::KIND_WRITE;
      else if (roll < 90) q.kind = mrfb_pkg::KIND_READ;
      else q.kind = mrfb_pkg::KIND_QUERY;
      q.frame_end = ($urandom_range(9) < 7);
    end else begin
      if (roll < 5) q.kind = mrfb_pkg::KIND_LOAD;
      else if (roll < 45) q.kind = mrfb_pkg::KIND_WRITE;
      else if (roll < 70) q.kind = mrfb_pkg::KIND_READ;
      else if (roll < 84) q.kind = mrfb_pkg::KIND_QUERY;
      else if (roll < 90) q.kind = mrfb_pkg::KIND_ADVANCE;
      else if (roll < 94) q.kind = kind_t'($urandom_range(7, mrfb_pkg::KIND_ADVANCE + 1));
      else q.kind = kind_t'($urandom_range(mrfb_pkg::KIND_QUERY,
                                           mrfb_pkg::KIND_WRITE));   // stray name
      q.frame_end = ($urandom_range(3) == 0);
    end

    // addressed requests go mostly to loaded entries
    if (roll < 94 || mix == MIX_FILL) begin
      case (q.kind)
        mrfb_pkg::KIND_LOAD: begin
          if ($urandom_range(1)) q.producer = id_pool[$urandom_range(3)];
          if ($urandom_range(2) != 0) q.name = tag_pool[$urandom_range(3)];
        end
        mrfb_pkg::KIND_WRITE: begin
          q.name     = ring_tag[pick];
          q.producer = ($urandom_range(9) == 0) ? $urandom : ring_owner[pick];
          if ($urandom_range(99) < 85) q.pos = pos_t'($urandom_range(len - 1));
        end
        mrfb_pkg::KIND_READ, mrfb_pkg::KIND_QUERY: begin
          q.name = ring_tag[pick];
          if ($urandom_range(99) < 85) q.pos = pos_t'($urandom_range(len - 1));
        end
        default: ;
      endcase
    end

    // never fetch a sample that was never stored
    if (q.kind == mrfb_pkg::KIND_READ) begin
      hit = find_ring(1'b0, '0, q.name);
      if (hit < RINGS && q.pos < len) begin
        frame = (tail_idx[hit] + 32'(q.foff)) % FRAMES;
        ok    = sample_written[mem_addr(hit, frame, 32'(q.pos))];
        for (int t = 0; t < 8 && !ok; t++) begin
          q.foff = foff_t'($urandom_range(FRAMES - 1));
          q.pos  = pos_t'($urandom_range(len - 1));
          frame  = (tail_idx[hit] + 32'(q.foff)) % FRAMES;
          ok     = sample_written[mem_addr(hit, frame, 32'(q.pos))];
        end
        if (!ok) begin
          if (recent_ok[hit]) begin
            q.foff = foff_t'((recent_frame[hit] + FRAMES - tail_idx[hit]) % FRAMES);
            q.pos  = pos_t'(recent_pos[hit]);
          end else if (len < MAXBLK) q.pos = pos_t'($urandom_range(MAXBLK - 1, len));
          else q.kind = mrfb_pkg::KIND_QUERY;
        end
      end
    end
  endtask

  task automatic run_items(input mix_t mix, input int count);
    req_t q;
    for (int n = 0; n < count; n++) begin
      make_req(mix, q);
      send_req(q);
    end
  endtask

  // --------------------------------------------------------------- tests

  // entries hold zero after reset, so name 0 resolves to slot 0
  task automatic test_power_on_state();
    send_req(pack_req(mrfb_pkg::KIND_QUERY, '0, '0, '0, '0, '0, '0, 1'b0));
    send_req(pack_req(mrfb_pkg::KIND_QUERY, '0, '0, TAG_A, '0, '0, '0, 1'b0));
    for (int k = mrfb_pkg::KIND_ADVANCE + 1; k < 8; k++)
      send_req(pack_req(kind_t'(k), 3'd7, PROD_A, TAG_A, 5'd29, 6'd63, 32'hFFFF_FFFF, 1'b1));
    send_req(pack_req(mrfb_pkg::KIND_ADVANCE, '0, '0, '0, '0, '0, '0, 1'b0));
  endtask

  // lowest matching entry wins; writes also match the producer
  task automatic test_table_lookup();
    send_req(pack_req(mrfb_pkg::KIND_LOAD, 3'd0, PROD_A, TAG_A, '0, '0, '0, 1'b0));
    send_req(pack_req(mrfb_pkg::KIND_LOAD, 3'd3, 32'h1234_5678, TAG_N, '0, '0, '0, 1'b0));
    send_req(pack_req(mrfb_pkg::KIND_LOAD, 3'd7, '0, TAG_N, '0, '0, '0, 1'b0));
    send_req(pack_req(mrfb_pkg::KIND_WRITE, '0, PROD_A, TAG_A, '0, 6'd63, 32'hFFFF_FFFF, 1'b0));
    send_req(pack_req(mrfb_pkg::KIND_WRITE, '0, PROD_A, TAG_A, '0, 6'd0, 32'h0, 1'b1));
    send_req(pack_req(mrfb_pkg::KIND_READ, '0, '0, TAG_A, 5'd0, 6'd63, '0, 1'b0));
    send_req(pack_req(mrfb_pkg::KIND_READ, '0, '0, TAG_A, 5'd0, 6'd0, '0, 1'b0));
    send_req(pack_req(mrfb_pkg::KIND_WRITE, '0, 32'h0BAD_CAFE, TAG_A, '0, 6'd5, 32'h1, 1'b1));
    send_req(pack_req(mrfb_pkg::KIND_WRITE, '0, '0, TAG_N, '0, 6'd10, 32'hA5A5_5A5A, 1'b1));
    send_req(pack_req(mrfb_pkg::KIND_QUERY, '0, '0, TAG_N, '0, '0, '0, 1'b0));
    send_req(pack_req(mrfb_pkg::KIND_ADVANCE, '0, '0, '0, '0, '0, '0, 1'b0));
    // tail plus offset wraps back to frame 0
    send_req(pack_req(mrfb_pkg::KIND_READ, '0, '0, TAG_A, 5'd29, 6'd63, '0, 1'b0));
  endtask

  // positions past the block size: no store, frame still completes, read gives 0
  task automatic test_block_limits();
    write_block_size(7'd4);
    send_req(pack_req(mrfb_pkg::KIND_WRITE, '0, PROD_A, TAG_A, '0, 6'd40, 32'hDEAD_BEEF, 1'b1));
    send_req(pack_req(mrfb_pkg::KIND_READ, '0, '0, TAG_A, 5'd0, 6'd40, '0, 1'b0));
    send_req(pack_req(mrfb_pkg::KIND_WRITE, '0, PROD_A, TAG_A, '0, 6'd3, 32'h1357_9BDF, 1'b0));
    send_req(pack_req(mrfb_pkg::KIND_READ, '0, '0, TAG_A, 5'd1, 6'd3, '0, 1'b0));
  endtask

  task automatic test_traffic_at_sizes();
    block_t sizes[5];
    sizes = '{7'd127, 7'd64, 7'd0, 7'd65, 7'($urandom_range(63, 2))};
    foreach (sizes[i]) begin
      write_block_size(sizes[i]);
      run_items(MIX_NORMAL, 250);
    end
  endtask

  // one-sample frames, no advance: rings fill up and the count saturates
  task automatic test_ring_saturation();
    write_block_size(7'd1);
    run_items(MIX_FILL, 250);
  endtask

  // receiver stops for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    write_block_size(7'($urandom_range(64, 1)));
    hold_req <= hold_req + 1;
    run_items(MIX_NORMAL, 60);
  endtask

  task automatic test_streaming_burst();
    feed_calm = 1'b1;
    run_items(MIX_NORMAL, 200);
    feed_calm = 1'b0;
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    block_reg   = mrfb_pkg::BLOCK_RESET;
    fault_count = 0;
    feed_calm   = 1'b0;
    foreach (ring_owner[i]) begin
      ring_owner[i]   = '0;
      ring_tag[i]     = '0;
      head_idx[i]     = 0;
      tail_idx[i]     = 0;
      ready_frames[i] = 0;
      recent_ok[i]    = 1'b0;
    end
    foreach (sample_written[i]) sample_written[i] = 1'b0;
    id_pool  = '{32'h0, PROD_A, $urandom, $urandom};
    tag_pool = '{TAG_N, TAG_A, {$urandom, $urandom}, {$urandom, $urandom}};

    hold_req        <= 0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_kind         <= '0;
    in_ring_slot    <= '0;
    in_producer_id  <= '0;
    in_name_hash    <= '0;
    in_frame_offset <= '0;
    in_sample_pos   <= '0;
    in_sample_in    <= '0;
    in_frame_end    <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_block_size  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_on_state();
    test_table_lookup();
    test_block_limits();
    test_traffic_at_sizes();
    test_ring_saturation();
    test_output_backpressure();
    test_streaming_burst();

    settle_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && due_results.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stalls, one calm window, long hold on request
  initial begin : result_sink
    int rx_cycle;
    int hold_seen;
    int hold_left;
    rx_cycle  = 0;
    hold_seen = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_cycle >= 2000 && rx_cycle < 3500) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 12);
    end
  end

  // compare each accepted result with the oldest owed one
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_sample_out, out_available_count, out_has_room, out_not_found};
      if (due_results.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("unexpected result: word=%h avail=%0d room=%b missing=%b",
                   got.word, got.avail, got.room, got.missing);
      end else begin
        want = due_results.pop_front();
        if (got.word !== want.word || got.avail !== want.avail ||
            got.room !== want.room || got.missing !== want.missing) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display("result mismatch at %0t: expected word=%h avail=%0d room=%b missing=%b",
                     $realtime, want.word, want.avail, want.room, want.missing);
            $display("  got word=%h avail=%0d room=%b missing=%b",
                     got.word, got.avail, got.room, got.missing);
          end
        end
      end
    end
  end

  // watchdog: too long without any request moving on any port
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
